// ===== rtl/server_health_selector_assert.svh =====
// Assertion helpers for the selector RTL; clock clk, reset rst_n assumed in scope.
`ifndef SERVER_HEALTH_SELECTOR_ASSERT_SVH
`define SERVER_HEALTH_SELECTOR_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define SHS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define SHS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/shs_pkg.sv =====
package shs_pkg;

  // Operation codes of an input beat
  localparam logic [2:0] OP_SELECT  = 3'd0;
  localparam logic [2:0] OP_ADD_ONE = 3'd1;
  localparam logic [2:0] OP_ADD_THR = 3'd2;
  localparam logic [2:0] OP_DIV_FOUR = 3'd3;
  localparam logic [2:0] OP_CLEAR   = 3'd4;

  // Fixed field widths
  localparam int OP_W    = 3;
  localparam int SRV_W   = 3;
  localparam int SEND_W  = 8;
  localparam int MASK_W  = 8;
  localparam int CFG_W   = 4;
  // Server count after saturation is at most 16
  localparam int NCNT_W  = 5;

  // Retry phase held as five base-3 digits (0..242)
  localparam int PHASE_DIGITS = 5;
  localparam int LVL_W        = 3;
  localparam logic [LVL_W-1:0] LVL_MAX = 3'd5;

  typedef logic [1:0] trit_t;
  typedef trit_t [PHASE_DIGITS-1:0] phase_t;

  // Ternary increment; wraps from 242 to 0
  function automatic phase_t phase_inc(input phase_t p);
    phase_t r;
    logic   carry;
    r     = p;
    carry = 1'b1;
    for (int i = 0; i < PHASE_DIGITS; i++) begin
      if (carry) begin
        if (p[i] == 2'd2) begin
          r[i] = 2'd0;
        end else begin
          r[i]  = p[i] + 2'd1;
          carry = 1'b0;
        end
      end
    end
    return r;
  endfunction

  // Power of three dividing the phase, capped at five (phase zero gives five)
  function automatic logic [LVL_W-1:0] phase_level(input phase_t p);
    logic [LVL_W-1:0] lvl;
    lvl = LVL_MAX;
    for (int i = PHASE_DIGITS - 1; i >= 0; i--) begin
      if (p[i] != 2'd0) lvl = LVL_W'(i);
    end
    return lvl;
  endfunction

endpackage

// ===== rtl/server_health_selector.sv =====
// Select: a bit-serial remainder of send_count mod n gives the scan start, then a
//   pipelined sweep of the failure-count memory (one read per cycle, n = servers scanned),
//   then result staging in the output registers.
// Select with no servers, clear and others go straight to the result; updates read, write, result.
// Throughput: one item at a time; the next beat is taken once the FSM is back in idle.
// Reset: synchronous active-low; counts read as zero via per-entry valid bits, phase 0.
`include "server_health_selector_assert.svh"

module server_health_selector
  import shs_pkg::*;
#(
  parameter int MAX_SERVERS = 8,
  parameter int COUNT_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_server_count,
  // input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [SRV_W-1:0]  in_server,
  input  logic [SEND_W-1:0] in_send_count,
  input  logic [MASK_W-1:0] in_usable_mask,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SRV_W-1:0]  out_chosen_server,
  output logic              out_found
);

  localparam int AW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int CW = COUNT_WIDTH;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MOD  = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_UPD  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  // control
  logic [2:0]        state_r, state_nxt;
  logic [CFG_W-1:0]  server_count_r;
  phase_t            phase_r, phase_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SRV_W-1:0]  out_chosen_r, out_chosen_nxt;
  logic              out_found_r, out_found_nxt;

  // latched beat
  logic [OP_W-1:0]   op_r;
  logic [AW-1:0]     srv_r;
  logic [SEND_W-1:0] sc_r;
  logic [MASK_W-1:0] mask_r;

  // remainder unit and sweep
  logic [2:0]        bit_r, bit_nxt;
  logic [NCNT_W-1:0] rem_r, rem_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [NCNT_W-1:0] iss_r, iss_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     epos_r, epos_nxt;
  logic              qf_r, qf_nxt;
  logic [AW-1:0]     qidx_r, qidx_nxt;
  logic              fbf_r, fbf_nxt;
  logic [AW-1:0]     fbidx_r, fbidx_nxt;
  logic              res_found_r, res_found_nxt;
  logic [AW-1:0]     res_idx_r, res_idx_nxt;

  // failure-count memory
  logic [CW-1:0]          mem [MAX_SERVERS];
  logic [MAX_SERVERS-1:0] vld_r;
  logic [CW-1:0]          rd_data_r;
  logic                   rd_vld_r;
  logic                   rd_en, wr_en, clr_all;
  logic [AW-1:0]          rd_addr;
  logic [CW-1:0]          wr_data;

  // combinational helpers
  logic              in_accept;
  logic [NCNT_W-1:0] n_sat;
  logic [NCNT_W-1:0] srv_ext;
  logic              srv_ok;
  logic [NCNT_W-1:0] rem_shift, rem_step, start;
  logic [NCNT_W-1:0] pos_inc, epos_ext;
  logic [CW-1:0]     cur_cnt;
  logic [CW:0]       cnt_sum;
  logic [LVL_W-1:0]  cnt_lvl, ph_lvl;
  logic              ev_usable, ev_qual, ev_fb;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_accept = in_valid && in_ready;

  assign out_valid         = out_valid_r;
  assign out_chosen_server = out_chosen_r;
  assign out_found         = out_found_r;

  // server count clipped to the memory depth
  assign n_sat = (NCNT_W'(server_count_r) > NCNT_W'(MAX_SERVERS)) ?
                 NCNT_W'(MAX_SERVERS) : NCNT_W'(server_count_r);

  assign srv_ext = NCNT_W'(in_server);
  assign srv_ok  = (srv_ext < NCNT_W'(MAX_SERVERS));

  // one restoring step of send_count mod n
  assign rem_shift = {rem_r[NCNT_W-2:0], sc_r[bit_r]};
  assign rem_step  = (rem_shift >= n_sat) ? (rem_shift - n_sat) : rem_shift;
  assign start     = (rem_step == '0) ? (n_sat - NCNT_W'(1)) : (rem_step - NCNT_W'(1));

  assign pos_inc  = NCNT_W'(pos_r) + NCNT_W'(1);
  assign epos_ext = NCNT_W'(epos_r);

  // entry under evaluation; a never-written entry reads as zero
  assign cur_cnt   = rd_vld_r ? rd_data_r : '0;
  assign cnt_lvl   = (cur_cnt >= CW'(LVL_MAX)) ? LVL_MAX : cur_cnt[LVL_W-1:0];
  assign ph_lvl    = phase_level(phase_r);
  assign ev_usable = (epos_ext < NCNT_W'(MASK_W)) && mask_r[epos_ext[2:0]];
  assign ev_qual   = ev_usable && (cnt_lvl <= ph_lvl);
  assign ev_fb     = ev_usable && (cur_cnt != '0);

  // saturating add and quarter for the update path
  assign cnt_sum = {1'b0, cur_cnt} + ((op_r == OP_ADD_THR) ? (CW+1)'(3) : (CW+1)'(1));

  always_comb begin
    wr_data = cnt_sum[CW] ? {CW{1'b1}} : cnt_sum[CW-1:0];
    if (op_r == OP_DIV_FOUR) wr_data = cur_cnt >> 2;
  end

  // main sequencer
  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_chosen_nxt = out_chosen_r;
    out_found_nxt  = out_found_r;
    bit_nxt        = bit_r;
    rem_nxt        = rem_r;
    pos_nxt        = pos_r;
    iss_nxt        = iss_r;
    pend_nxt       = pend_r;
    epos_nxt       = epos_r;
    qf_nxt         = qf_r;
    qidx_nxt       = qidx_r;
    fbf_nxt        = fbf_r;
    fbidx_nxt      = fbidx_r;
    res_found_nxt  = res_found_r;
    res_idx_nxt    = res_idx_r;
    rd_en          = 1'b0;
    rd_addr        = pos_r;
    wr_en          = 1'b0;
    clr_all        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          res_found_nxt = 1'b0;
          res_idx_nxt   = '0;
          priority if (in_operation == OP_SELECT) begin
            phase_nxt = phase_inc(phase_r);
            bit_nxt   = 3'd7;
            rem_nxt   = '0;
            state_nxt = (n_sat == '0) ? ST_DONE : ST_MOD;
          end else if (in_operation == OP_ADD_ONE || in_operation == OP_ADD_THR ||
                       in_operation == OP_DIV_FOUR) begin
            rd_en     = srv_ok;
            rd_addr   = srv_ext[AW-1:0];
            state_nxt = srv_ok ? ST_UPD : ST_DONE;
          end else if (in_operation == OP_CLEAR) begin
            clr_all   = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end

      ST_MOD: begin
        rem_nxt = rem_step;
        bit_nxt = bit_r - 3'd1;
        if (bit_r == 3'd0) begin
          pos_nxt   = start[AW-1:0];
          iss_nxt   = '0;
          pend_nxt  = 1'b0;
          qf_nxt    = 1'b0;
          fbf_nxt   = 1'b0;
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // issue side: one read per cycle in scan order
        if (iss_r != n_sat) begin
          rd_en    = 1'b1;
          rd_addr  = pos_r;
          epos_nxt = pos_r;
          pend_nxt = 1'b1;
          pos_nxt  = (pos_inc == n_sat) ? '0 : pos_inc[AW-1:0];
          iss_nxt  = iss_r + NCNT_W'(1);
        end else begin
          pend_nxt = 1'b0;
        end
        // evaluate side: first qualifying and first failing usable server
        if (pend_r) begin
          if (!qf_r && ev_qual) begin
            qf_nxt   = 1'b1;
            qidx_nxt = epos_r;
          end
          if (!fbf_r && ev_fb) begin
            fbf_nxt   = 1'b1;
            fbidx_nxt = epos_r;
          end
        end
        if (iss_r == n_sat && !pend_r) begin
          res_found_nxt = qf_r || fbf_r;
          res_idx_nxt   = qf_r ? qidx_r : (fbf_r ? fbidx_r : '0);
          state_nxt     = ST_DONE;
        end
      end

      ST_UPD: begin
        wr_en     = 1'b1;
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = res_found_r;
          out_chosen_nxt = NCNT_W'(res_idx_r) < NCNT_W'(1 << SRV_W) ?
                           SRV_W'(res_idx_r) : SRV_W'(res_idx_r);
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      server_count_r <= CFG_W'(1);
      phase_r        <= '0;
      out_valid_r    <= 1'b0;
      vld_r          <= '0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) server_count_r <= cfg_server_count;
      if (clr_all) begin
        vld_r <= '0;
      end else if (wr_en) begin
        vld_r[srv_r] <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r   <= in_operation;
      srv_r  <= srv_ext[AW-1:0];
      sc_r   <= in_send_count;
      mask_r <= in_usable_mask;
    end
    out_chosen_r <= out_chosen_nxt;
    out_found_r  <= out_found_nxt;
    bit_r        <= bit_nxt;
    rem_r        <= rem_nxt;
    pos_r        <= pos_nxt;
    iss_r        <= iss_nxt;
    pend_r       <= pend_nxt;
    epos_r       <= epos_nxt;
    qf_r         <= qf_nxt;
    qidx_r       <= qidx_nxt;
    fbf_r        <= fbf_nxt;
    fbidx_r      <= fbidx_nxt;
    res_found_r  <= res_found_nxt;
    res_idx_r    <= res_idx_nxt;
  end

  // failure-count memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[srv_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
  end

  // checks
  `SHS_ASSERT_NOW(a_found_in_range, state_r == ST_DONE && res_found_r, NCNT_W'(res_idx_r) < n_sat, "chosen server outside scanned range")
  `SHS_ASSERT_NOW(a_issue_bound, state_r == ST_SCAN, iss_r <= n_sat, "sweep issued more reads than servers")
  `SHS_ASSERT_NOW(a_write_only_upd, wr_en, state_r == ST_UPD && !rd_en, "memory write outside update step")
  `SHS_ASSERT_NEXT(a_phase_on_select, !(in_accept && in_operation == OP_SELECT), $stable(phase_r), "phase moved without a select")

endmodule

// ===== test/server_health_selector_check.sv =====
module server_health_selector_check
  import shs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_server_count,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [SRV_W-1:0]  in_server,
  input  logic [SEND_W-1:0] in_send_count,
  input  logic [MASK_W-1:0] in_usable_mask,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [SRV_W-1:0]  out_chosen_server,
  input  logic              out_found,
  output int unsigned       errors,
  output int unsigned       pending,
  output int unsigned       checked
);

  localparam int          NUM_SERVERS = 8;
  localparam int unsigned PHASE_WRAP  = 243;
  localparam int unsigned FAIL_SAT    = 32'h0000_FFFF;

  typedef struct packed {
    logic [SRV_W-1:0] chosen;
    logic             found;
  } pick_t;

  // Shadow copy of the selector state
  logic [CFG_W-1:0] servers_used;
  logic [15:0]      fail_cnt [NUM_SERVERS];
  int unsigned      retry_phase;
  pick_t            picks_due [$];

  // 3^min(fails,5): how many phase steps a failing server has to sit out
  function automatic int unsigned backoff_step(input int unsigned fails);
    int unsigned d;
    d = 1;
    for (int k = 0; k < 5 && k < fails; k++) d = d * 3;
    return d;
  endfunction

  function automatic logic [15:0] add_sat(input logic [15:0] a, input int unsigned b);
    int unsigned s;
    s = a + b;
    return (s > FAIL_SAT) ? 16'hFFFF : s[15:0];
  endfunction

  // Applies one input beat to the shadow state and returns the pick it yields
  function automatic pick_t pick_server(input logic [OP_W-1:0] op,
                                        input logic [SRV_W-1:0] srv,
                                        input logic [SEND_W-1:0] send,
                                        input logic [MASK_W-1:0] mask);
    pick_t       res;
    int unsigned n, start, ns, f;
    res = '0;
    case (op)
      OP_SELECT: begin
        n = (servers_used > NUM_SERVERS) ? NUM_SERVERS : 32'(servers_used);
        retry_phase = (retry_phase + 1) % PHASE_WRAP;
        if (n != 0) begin
          start = (send % n + n - 1) % n;
          // healthy servers, or failing ones whose backoff slot has come round
          for (int i = 0; i < n && !res.found; i++) begin
            ns = (start + i) % n;
            f  = 32'(fail_cnt[ns]);
            if (mask[ns] && (f == 0 || retry_phase % backoff_step(f) == 0)) begin
              res.chosen = SRV_W'(ns);
              res.found  = 1'b1;
            end
          end
          // fall back to any usable failing server
          for (int i = 0; i < n && !res.found; i++) begin
            ns = (start + i) % n;
            if (mask[ns] && fail_cnt[ns] != 0) begin
              res.chosen = SRV_W'(ns);
              res.found  = 1'b1;
            end
          end
        end
      end
      OP_ADD_ONE:  fail_cnt[srv] = add_sat(fail_cnt[srv], 1);
      OP_ADD_THR:  fail_cnt[srv] = add_sat(fail_cnt[srv], 3);
      OP_DIV_FOUR: fail_cnt[srv] = fail_cnt[srv] >> 2;
      OP_CLEAR: begin
        for (int i = 0; i < NUM_SERVERS; i++) fail_cnt[i] = '0;
      end
      default: ;
    endcase
    return res;
  endfunction

  // Watch all three channels at the rising edge
  always @(posedge clk) begin : watch
    pick_t due;
    if (!rst_n) begin
      servers_used = CFG_W'(1);
      retry_phase  = 0;
      for (int i = 0; i < NUM_SERVERS; i++) fail_cnt[i] = '0;
      picks_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) servers_used = cfg_server_count;
      // result beat first, so a same-edge input beat never pairs with it
      if (out_valid && out_ready) begin
        if (picks_due.size() == 0) begin
          $error("result beat with nothing outstanding: chosen_server %0d, found %0d",
                 out_chosen_server, out_found);
          errors++;
        end else begin
          due = picks_due.pop_front();
          checked++;
          if (out_chosen_server !== due.chosen) begin
            $error("chosen_server: expected %0d, actual %0d", due.chosen, out_chosen_server);
            errors++;
          end
          if (out_found !== due.found) begin
            $error("found: expected %0d, actual %0d", due.found, out_found);
            errors++;
          end
        end
      end
      if (in_valid && in_ready)
        picks_due.push_back(pick_server(in_operation, in_server, in_send_count,
                                        in_usable_mask));
    end
    pending = picks_due.size();
  end

endmodule

// ===== test/server_health_selector_test.sv =====
module server_health_selector_test;
  import shs_pkg::*;

  // Operation codes the block must ignore
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

  localparam int IDLE_LIMIT   = 400;
  localparam int PHASE_BEATS  = 80;
  localparam int HEAVY_ADDS   = 4;  // 3 * 4 = 12, well past the backoff cap
  localparam int SETTLE_CYCLES = 30;

  logic              clk;
  logic              rst_n;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_server_count;
  logic              in_valid;
  logic              in_ready;
  logic [OP_W-1:0]   in_operation;
  logic [SRV_W-1:0]  in_server;
  logic [SEND_W-1:0] in_send_count;
  logic [MASK_W-1:0] in_usable_mask;
  logic              out_valid;
  logic              out_ready;
  logic [SRV_W-1:0]  out_chosen_server;
  logic              out_found;

  int unsigned mismatches, awaiting, results_checked;
  int unsigned beats_sent, selects_sent, cfg_writes, cur_servers, quiet_cycles;
  bit          no_gaps;

  logic [CFG_W-1:0] count_plan [11] = '{4'd8, 4'd3, 4'd0, 4'd15, 4'd9, 4'd5,
                                        4'd2, 4'd7, 4'd6, 4'd4, 4'd1};

  server_health_selector dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_server_count  (cfg_server_count),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_server         (in_server),
    .in_send_count     (in_send_count),
    .in_usable_mask    (in_usable_mask),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_chosen_server (out_chosen_server),
    .out_found         (out_found)
  );

  server_health_selector_check pick_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_server_count  (cfg_server_count),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_server         (in_server),
    .in_send_count     (in_send_count),
    .in_usable_mask    (in_usable_mask),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_chosen_server (out_chosen_server),
    .out_found         (out_found),
    .errors            (mismatches),
    .pending           (awaiting),
    .checked           (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // One input beat: optional gap, then hold until accepted
  task automatic send_beat(input logic [OP_W-1:0] op, input logic [SRV_W-1:0] srv,
                           input logic [SEND_W-1:0] sc, input logic [MASK_W-1:0] mask);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       = 1'b1;
    in_operation   = op;
    in_server      = srv;
    in_send_count  = sc;
    in_usable_mask = mask;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    if (op == OP_SELECT) selects_sent++;
  endtask

  // Stop sending and wait until every result beat is back
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (awaiting != 0) @(negedge clk);
  endtask

  task automatic write_server_count(input logic [CFG_W-1:0] value);
    drain();
    cfg_server_count = value;
    cfg_valid        = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid   = 1'b0;
    cur_servers = 32'(value);
    cfg_writes++;
  endtask

  // Weighted mix: selects dominate, penalties keep the counts spread out
  task automatic send_random();
    int unsigned       pick, lim;
    logic [OP_W-1:0]   op;
    logic [SRV_W-1:0]  srv;
    logic [SEND_W-1:0] sc;
    logic [MASK_W-1:0] mask;
    pick = $urandom_range(0, 99);
    if (pick < 45)      op = OP_SELECT;
    else if (pick < 65) op = OP_ADD_ONE;
    else if (pick < 77) op = OP_ADD_THR;
    else if (pick < 89) op = OP_DIV_FOUR;
    else if (pick < 92) op = OP_CLEAR;
    else                op = OP_W'($urandom_range(OP_SPARE_A, OP_SPARE_C));
    // mostly hit servers that the scan actually visits
    lim = (cur_servers > 8) ? 8 : cur_servers;
    if (lim != 0 && $urandom_range(0, 9) < 7) srv = SRV_W'($urandom_range(0, lim - 1));
    else                                      srv = SRV_W'($urandom_range(0, 7));
    case ($urandom_range(0, 9))
      0:       sc = '0;
      1:       sc = '1;
      default: sc = SEND_W'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 3))
      0:       mask = '1;
      1:       mask = MASK_W'($urandom & $urandom);
      default: mask = MASK_W'($urandom);
    endcase
    send_random_beat: send_beat(op, srv, sc, mask);
  endtask

  // Result side: random stall before each beat
  initial begin : result_side
    int unsigned stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 5);
      @(negedge clk);
      if (stall != 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Watchdog: too many cycles without any beat on any channel
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("no beat for %0d cycles", IDLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_n            = 1'b0;
    cfg_valid        = 1'b0;
    cfg_server_count = '0;
    in_valid         = 1'b0;
    in_operation     = OP_SELECT;
    in_server        = '0;
    in_send_count    = '0;
    in_usable_mask   = '0;
    no_gaps          = 1'b0;
    cur_servers      = 1;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset count of one server
    send_beat(OP_SELECT,  3'd0, 8'd1,   8'h00);
    send_beat(OP_SELECT,  3'd0, 8'd0,   8'hFF);
    send_beat(OP_SPARE_C, 3'd7, 8'hFF,  8'hFF);

    // Directed: all eight servers, mixed health
    write_server_count(4'd8);
    send_beat(OP_ADD_ONE,  3'd0, 8'd0,   8'h00);
    send_beat(OP_ADD_THR,  3'd1, 8'd0,   8'h00);
    send_beat(OP_ADD_THR,  3'd7, 8'hFF,  8'hFF);
    send_beat(OP_SELECT,   3'd0, 8'd1,   8'hFF);
    send_beat(OP_SELECT,   3'd0, 8'd0,   8'hFF);   // scan starts at the last server
    send_beat(OP_SELECT,   3'd0, 8'hFF,  8'h80);
    send_beat(OP_SELECT,   3'd0, 8'd2,   8'h03);
    send_beat(OP_DIV_FOUR, 3'd1, 8'd0,   8'h00);
    send_beat(OP_DIV_FOUR, 3'd7, 8'd0,   8'h00);
    send_beat(OP_ADD_ONE,  3'd3, 8'd0,   8'h00);
    send_beat(OP_SELECT,   3'd0, 8'd4,   8'h08);   // only a failing server usable
    send_beat(OP_SPARE_A,  3'd2, 8'h55,  8'hAA);
    send_beat(OP_SPARE_B,  3'd5, 8'hAA,  8'h55);
    send_beat(OP_CLEAR,    3'd0, 8'd0,   8'h00);
    send_beat(OP_SELECT,   3'd0, 8'd128, 8'h7F);

    // Directed: no servers, then a count above the limit
    write_server_count(4'd0);
    send_beat(OP_SELECT,   3'd0, 8'd9,   8'hFF);
    write_server_count(4'd15);
    send_beat(OP_SELECT,   3'd0, 8'd0,   8'hFF);
    send_beat(OP_ADD_ONE,  3'd4, 8'd0,   8'h00);
    send_beat(OP_SELECT,   3'd0, 8'd5,   8'h10);

    // Random phases, one server count each; some run without any idling
    foreach (count_plan[p]) begin
      write_server_count(count_plan[p]);
      no_gaps = (p % 4 == 2);
      for (int i = 0; i < PHASE_BEATS; i++) begin
        if (i == PHASE_BEATS / 2) drain();
        send_random();
      end
    end

    // Drive one count well past the backoff cap, then probe it
    write_server_count(4'd8);
    no_gaps = 1'b1;
    send_beat(OP_CLEAR, 3'd0, 8'd0, 8'h00);
    for (int i = 0; i < HEAVY_ADDS; i++) send_beat(OP_ADD_THR, 3'd6, 8'd0, 8'h00);
    send_beat(OP_ADD_THR,  3'd6, 8'd0, 8'h00);
    send_beat(OP_ADD_ONE,  3'd6, 8'd0, 8'h00);
    send_beat(OP_SELECT,   3'd0, 8'd7, 8'h40);
    send_beat(OP_DIV_FOUR, 3'd6, 8'd0, 8'h00);
    send_beat(OP_SELECT,   3'd0, 8'd7, 8'h40);
    send_beat(OP_SELECT,   3'd0, 8'd7, 8'h41);
    no_gaps = 1'b0;

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("covered %0d input beats (%0d selects) and %0d server-count writes",
             beats_sent, selects_sent, cfg_writes);
    $display("%0d results checked, including zero, over-limit and heavily failing counts",
             results_checked);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
